// ===== hdl/gpuf_pkg.sv =====
// Shared constants for the grid percolation union-find block.
package gpuf_pkg;
   localparam int MAX_SIDE_DEF = 16;
   localparam int SIDE_W       = 5;
   localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd16;
endpackage

// ===== hdl/gpuf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module gpuf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hdl/grid_percolation_union_find.sv =====
// Streaming 3-D percolation: weighted union-find over a cubic grid, one site per item.
// A site is written, then each join slot is tried in turn (a blocked site skips them); an open
// neighbor is read and checked, and a join walks to both roots, linking them by size when they
// differ. Last, the top and bottom roots are compared; a grid's first site also sets up both ends.
// One item at a time: the next is taken once idle, as early as the cycle the result appears.
// Reset clears the grid position and sets the side register to 16; memories are not cleared.
module grid_percolation_union_find #(
   parameter int MAX_SIDE = gpuf_pkg::MAX_SIDE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_site_open,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_percolates,
   output logic                        rsp_grid_done,
   input  logic                        csr_write,
   input  logic [gpuf_pkg::SIDE_W-1:0] csr_wdata
);
   import gpuf_pkg::*;

   localparam int SITES = MAX_SIDE * MAX_SIDE * MAX_SIDE;
   localparam int NODES = SITES + 2;
   localparam int NW    = $clog2(NODES);
   localparam int OW    = $clog2(SITES + 1);
   localparam int SW    = $clog2(MAX_SIDE + 1);
   localparam int PW    = $clog2(MAX_SIDE);
   localparam int LAST_SLOT = 5;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL1, ST_MUL2, ST_INIT_TOP, ST_INIT_BOT, ST_SITE_WR, ST_SLOT,
      ST_OPEN_RD, ST_OPEN_CHK, ST_FIND_RD, ST_FIND_WALK, ST_SZ_A, ST_SZ_B,
      ST_LINK, ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [SIDE_W-1:0] side_ff, side_in;
   logic [PW-1:0]     layer_ff, layer_in, row_ff, row_in, col_ff, col_in;
   logic [NW-1:0]     idx_ff, idx_in, nn_ff, nn_in, bot_ff, bot_in;
   logic [NW-1:0]     walk_ff, walk_in, b_ff, b_in, ra_ff, ra_in, sa_ff, sa_in;
   logic [2:0]        slot_ff, slot_in;
   logic              second_ff, second_in, final_ff, final_in, open_ff, open_in;
   logic              pct_ff, pct_in;
   logic              rsp_valid_ff, rsp_valid_in, rsp_pct_ff, rsp_pct_in;
   logic              rsp_done_ff, rsp_done_in;

   logic [SW-1:0] n_eff;
   logic [NW-1:0] n_w, nb;
   logic          nb_check, slot_en, last_site, at_start;

   logic          p_we, s_we, o_we;
   logic [NW-1:0] p_wa, p_wd, p_ra, p_rd, s_wa, s_wd, s_ra, s_rd;
   logic [OW-1:0] o_wa, o_ra;
   logic [0:0]    o_wd, o_rd;

   gpuf_ram #(.WIDTH(NW), .DEPTH(NODES)) u_parent (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd));
   gpuf_ram #(.WIDTH(NW), .DEPTH(NODES)) u_size (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data(s_rd));
   gpuf_ram #(.WIDTH(1), .DEPTH(SITES + 1)) u_open (
      .clock(clock), .wr_en(o_we), .wr_addr(o_wa), .wr_data(o_wd),
      .rd_addr(o_ra), .rd_data(o_rd));

   always_comb begin
      if (side_ff < SIDE_W'(2)) begin
         n_eff = SW'(2);
      end else if (32'(side_ff) > 32'(MAX_SIDE)) begin
         n_eff = SW'(MAX_SIDE);
      end else begin
         n_eff = SW'(side_ff);
      end
   end

   assign n_w       = NW'(n_eff);
   assign at_start  = (layer_ff == '0) && (row_ff == '0) && (col_ff == '0);
   assign last_site = (SW'(layer_ff) == n_eff - SW'(1)) && (SW'(row_ff) == n_eff - SW'(1))
                      && (SW'(col_ff) == n_eff - SW'(1));

   // Join slots in model order: top, bottom, previous layer, previous row, previous column.
   always_comb begin
      slot_en  = 1'b0;
      nb_check = 1'b0;
      nb       = idx_ff;
      case (slot_ff)
         3'd0: slot_en = (layer_ff == '0);
         3'd1: slot_en = (SW'(layer_ff) == n_eff - SW'(1));
         3'd2: begin
            slot_en = (layer_ff != '0); nb_check = 1'b1; nb = idx_ff - nn_ff;
         end
         3'd3: begin
            slot_en = (row_ff != '0); nb_check = 1'b1; nb = idx_ff - n_w;
         end
         3'd4: begin
            slot_en = (col_ff != '0); nb_check = 1'b1; nb = idx_ff - NW'(1);
         end
         default: slot_en = 1'b0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      layer_in     = layer_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      idx_in       = idx_ff;
      nn_in        = nn_ff;
      bot_in       = bot_ff;
      walk_in      = walk_ff;
      b_in         = b_ff;
      ra_in        = ra_ff;
      sa_in        = sa_ff;
      slot_in      = slot_ff;
      second_in    = second_ff;
      final_in     = final_ff;
      open_in      = open_ff;
      pct_in       = pct_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pct_in   = rsp_pct_ff;
      rsp_done_in  = rsp_done_ff;
      p_we = 1'b0; p_wa = idx_ff; p_wd = idx_ff; p_ra = walk_ff;
      s_we = 1'b0; s_wa = idx_ff; s_wd = NW'(1); s_ra = ra_ff;
      o_we = 1'b0; o_wa = OW'(idx_ff); o_wd = open_ff; o_ra = OW'(nb);
      // A register write takes the idle cycle, so no item is taken with it.
      req_ready = (state_ff == ST_IDLE) && !csr_write;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_write) begin
               side_in  = csr_wdata;
               layer_in = '0;
               row_in   = '0;
               col_in   = '0;
            end else if (req_valid) begin
               open_in  = req_site_open;
               if (at_start) begin
                  idx_in   = NW'(1);
                  state_in = ST_MUL1;
               end else begin
                  state_in = ST_SITE_WR;
               end
            end
         end
         ST_MUL1: begin
            nn_in    = n_w * n_w;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            bot_in   = nn_ff * n_w + NW'(1);
            state_in = ST_INIT_TOP;
         end
         ST_INIT_TOP: begin
            p_we = 1'b1; p_wa = '0; p_wd = '0;
            s_we = 1'b1; s_wa = '0;
            state_in = ST_INIT_BOT;
         end
         ST_INIT_BOT: begin
            p_we = 1'b1; p_wa = bot_ff; p_wd = bot_ff;
            s_we = 1'b1; s_wa = bot_ff;
            state_in = ST_SITE_WR;
         end
         ST_SITE_WR: begin
            p_we = 1'b1;
            s_we = 1'b1;
            o_we = 1'b1;
            slot_in  = '0;
            state_in = ST_SLOT;
         end
         ST_SLOT: begin
            second_in = 1'b0;
            if (slot_ff == 3'(LAST_SLOT) || !open_ff) begin
               final_in = 1'b1;
               walk_in  = '0;
               b_in     = bot_ff;
               state_in = ST_FIND_RD;
            end else if (slot_en && nb_check) begin
               state_in = ST_OPEN_RD;
            end else if (slot_en) begin
               final_in = 1'b0;
               walk_in  = idx_ff;
               b_in     = (slot_ff == 3'd0) ? '0 : bot_ff;
               state_in = ST_FIND_RD;
            end else begin
               slot_in = slot_ff + 3'd1;
            end
         end
         ST_OPEN_RD: begin
            state_in = ST_OPEN_CHK;
         end
         ST_OPEN_CHK: begin
            if (o_rd[0]) begin
               final_in = 1'b0;
               walk_in  = nb;
               b_in     = idx_ff;
               state_in = ST_FIND_RD;
            end else begin
               slot_in  = slot_ff + 3'd1;
               state_in = ST_SLOT;
            end
         end
         ST_FIND_RD: begin
            state_in = ST_FIND_WALK;
         end
         ST_FIND_WALK: begin
            if (p_rd != walk_ff) begin
               // Not a root yet: follow the link and read the next parent at once.
               walk_in = p_rd;
               p_ra    = p_rd;
            end else if (!second_ff) begin
               ra_in     = walk_ff;
               walk_in   = b_ff;
               second_in = 1'b1;
               state_in  = ST_FIND_RD;
            end else if (final_ff) begin
               pct_in   = (ra_ff == walk_ff);
               state_in = ST_DONE;
            end else if (ra_ff == walk_ff) begin
               slot_in  = slot_ff + 3'd1;
               state_in = ST_SLOT;
            end else begin
               s_ra     = ra_ff;
               state_in = ST_SZ_A;
            end
         end
         ST_SZ_A: begin
            s_ra     = walk_ff;
            sa_in    = s_rd;
            state_in = ST_SZ_B;
         end
         ST_SZ_B: begin
            s_ra     = walk_ff;
            state_in = ST_LINK;
         end
         ST_LINK: begin
            // The strictly larger set keeps its root; on a tie the first root is hung.
            p_we = 1'b1;
            s_we = 1'b1;
            s_wd = sa_ff + s_rd;
            if (sa_ff > s_rd) begin
               p_wa = walk_ff; p_wd = ra_ff; s_wa = ra_ff;
            end else begin
               p_wa = ra_ff; p_wd = walk_ff; s_wa = walk_ff;
            end
            slot_in  = slot_ff + 3'd1;
            state_in = ST_SLOT;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pct_in   = pct_ff;
               rsp_done_in  = last_site;
               idx_in       = idx_ff + NW'(1);
               if (SW'(col_ff) == n_eff - SW'(1)) begin
                  col_in = '0;
                  if (SW'(row_ff) == n_eff - SW'(1)) begin
                     row_in = '0;
                     if (SW'(layer_ff) == n_eff - SW'(1)) begin
                        layer_in = '0;
                     end else begin
                        layer_in = layer_ff + PW'(1);
                     end
                  end else begin
                     row_in = row_ff + PW'(1);
                  end
               end else begin
                  col_in = col_ff + PW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         side_ff      <= SIDE_RESET;
         layer_ff     <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         layer_ff     <= layer_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      nn_ff       <= nn_in;
      bot_ff      <= bot_in;
      walk_ff     <= walk_in;
      b_ff        <= b_in;
      ra_ff       <= ra_in;
      sa_ff       <= sa_in;
      slot_ff     <= slot_in;
      second_ff   <= second_in;
      final_ff    <= final_in;
      open_ff     <= open_in;
      pct_ff      <= pct_in;
      rsp_pct_ff  <= rsp_pct_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_percolates = rsp_pct_ff;
   assign rsp_grid_done  = rsp_done_ff;
endmodule

// ===== test/gpuf_checker.sv =====
// Checker for the grid percolation union-find block: predicts and compares results.
`timescale 1ns / 100ps
module gpuf_checker #(
   parameter int MAX_SIDE = gpuf_pkg::MAX_SIDE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_site_open,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_percolates,
   input  logic                        rsp_grid_done,
   input  logic                        csr_write,
   input  logic [gpuf_pkg::SIDE_W-1:0] csr_wdata,
   output int                          fail_count,
   output int                          pending_count
);
   localparam int NODES = MAX_SIDE * MAX_SIDE * MAX_SIDE + 2;

   typedef struct packed {
      logic percolates;
      logic grid_done;
   } site_result_type;

   int unsigned  link_of[NODES];
   int unsigned  weight_of[NODES];
   bit           is_open[NODES];
   int unsigned  layer_i, row_i, col_i;
   logic [gpuf_pkg::SIDE_W-1:0] side_reg;
   site_result_type pending_results[$];

   assign pending_count = pending_results.size();

   function automatic int unsigned root_of(int unsigned x);
      while (link_of[x] != x) x = link_of[x];
      return x;
   endfunction

   function automatic void merge(int unsigned a, int unsigned b);
      int unsigned ra, rb;
      ra = root_of(a);
      rb = root_of(b);
      if (ra == rb) return;
      if (weight_of[ra] > weight_of[rb]) begin
         link_of[rb] = ra;
         weight_of[ra] += weight_of[rb];
      end else begin
         link_of[ra] = rb;
         weight_of[rb] += weight_of[ra];
      end
   endfunction

   function automatic site_result_type predict_site(bit open_flag);
      int unsigned n, bottom, idx;
      site_result_type r;
      n = side_reg < 2 ? 2 : (side_reg > MAX_SIDE ? MAX_SIDE : side_reg);
      bottom = n * n * n + 1;
      if (layer_i >= n || row_i >= n || col_i >= n) begin
         layer_i = 0;
         row_i = 0;
         col_i = 0;
      end
      if (layer_i == 0 && row_i == 0 && col_i == 0) begin
         link_of[0] = 0;
         weight_of[0] = 1;
         link_of[bottom] = bottom;
         weight_of[bottom] = 1;
      end
      idx = layer_i * n * n + row_i * n + col_i + 1;
      link_of[idx] = idx;
      weight_of[idx] = 1;
      is_open[idx] = open_flag;
      if (open_flag) begin
         if (layer_i == 0) merge(idx, 0);
         if (layer_i == n - 1) merge(idx, bottom);
         if (layer_i > 0 && is_open[idx - n * n]) merge(idx - n * n, idx);
         if (row_i > 0 && is_open[idx - n]) merge(idx - n, idx);
         if (col_i > 0 && is_open[idx - 1]) merge(idx - 1, idx);
      end
      r.percolates = root_of(0) == root_of(bottom);
      r.grid_done = layer_i == n - 1 && row_i == n - 1 && col_i == n - 1;
      col_i++;
      if (col_i >= n) begin
         col_i = 0;
         row_i++;
         if (row_i >= n) begin
            row_i = 0;
            layer_i++;
            if (layer_i >= n) layer_i = 0;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      site_result_type want;
      if (reset) begin
         layer_i = 0;
         row_i = 0;
         col_i = 0;
         side_reg = gpuf_pkg::SIDE_RESET;
         fail_count = 0;
      end else begin
         if (csr_write) begin
            side_reg = csr_wdata;
            layer_i = 0;
            row_i = 0;
            col_i = 0;
         end
         if (req_valid && req_ready) begin
            pending_results = {pending_results, predict_site(req_site_open)};
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result item");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (want.percolates !== rsp_percolates) begin
                  $error("percolates: expected %0b actual %0b", want.percolates, rsp_percolates);
                  fail_count++;
               end
               if (want.grid_done !== rsp_grid_done) begin
                  $error("grid_done: expected %0b actual %0b", want.grid_done, rsp_grid_done);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

// ===== test/tb_grid_percolation_union_find.sv =====
// Testbench top for the grid percolation union-find block: stimulus and verdict.
`timescale 1ns / 100ps
module tb_grid_percolation_union_find;
   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_site_open = 0, rsp_ready = 0, csr_write = 0;
   logic [gpuf_pkg::SIDE_W-1:0] csr_wdata = '0;
   logic req_ready, rsp_valid, rsp_percolates, rsp_grid_done;
   int   fail_count, pending_count;
   int   cycle_count = 0;
   bit   hold_off = 0;

   always #10 clock = ~clock;

   grid_percolation_union_find i_dut (.*);
   gpuf_checker i_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: random stalls, long hold-off on request, and calm stretches.
   initial begin
      int calm;
      calm = 0;
      forever begin
         @(negedge clock);
         if (hold_off) rsp_ready <= 0;
         else if (calm > 0) begin
            rsp_ready <= 1;
            calm--;
         end else begin
            rsp_ready <= $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 99) == 0) calm = $urandom_range(50, 400);
         end
      end
   end

   task automatic send_site(bit open_flag);
      req_valid <= 1;
      req_site_open <= open_flag;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic idle_gap();
      req_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   task automatic drain_then_write(logic [gpuf_pkg::SIDE_W-1:0] side);
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      csr_write <= 1;
      csr_wdata <= side;
      @(negedge clock);
      csr_write <= 0;
   endtask

   // Sends a burst-shaped stream of sites with the given open percentage.
   task automatic send_stream(int count, int open_pct);
      int burst;
      burst = 0;
      repeat (count) begin
         if (burst == 0) begin
            idle_gap();
            burst = $urandom_range(1, 20);
         end
         send_site($urandom_range(0, 99) < open_pct);
         burst--;
      end
   endtask

   initial begin
      logic [gpuf_pkg::SIDE_W-1:0] sides[5] = '{5'd2, 5'd0, 5'd1, 5'd3, 5'd31};
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // Side 2: all open, then all blocked, then one column straight through.
      drain_then_write(5'd2);
      repeat (8) send_site(1);
      repeat (8) send_site(0);
      send_site(1); send_site(0); send_site(0); send_site(0);
      send_site(1); send_site(0); send_site(0); send_site(0);
      // Restart mid-grid by a write.
      send_site(1);
      drain_then_write(5'd3);
      // Long receiver hold-off while the sender keeps offering.
      fork
         begin
            hold_off = 1;
            repeat (200) @(negedge clock);
            hold_off = 0;
         end
         repeat (20) send_site($urandom_range(0, 1) == 1);
      join
      send_stream(120, 60);
      foreach (sides[k]) begin
         drain_then_write(sides[k]);
         send_stream(sides[k] == 5'd31 ? 4096 / 32 : 70, $urandom_range(40, 80));
      end
      drain_then_write(5'd4);
      send_stream(130, 65);
      drain_then_write(5'd16);
      send_stream(150, 100);
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
hdl/gpuf_pkg.sv
hdl/gpuf_ram.sv
hdl/grid_percolation_union_find.sv
test/gpuf_checker.sv
test/tb_grid_percolation_union_find.sv
